FILE: rtl/dirty_tracked_cell_buffer_core_assert.svh
// Assertion macros for the dirty-tracked cell buffer.
// Included by files that check their own logic; no other dependencies.
`ifndef DIRTY_TRACKED_CELL_BUFFER_CORE_ASSERT_SVH
`define DIRTY_TRACKED_CELL_BUFFER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define DTCB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dtcb assertion failed");

`define DTCB_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dtcb assertion failed");

`else

`define DTCB_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define DTCB_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/dtcb_pkg.sv
// Shared constants, codes, command/status types and helpers of the cell buffer.
// No dependencies.
`default_nettype none

package dtcb_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 16;

  localparam int FUNC_W = 3;
  localparam int COL_W  = 5;
  localparam int ROW_W  = 4;
  localparam int DATA_W = 8;

  localparam int DWORD_W = 32;
  localparam int DBIT_W  = 5;

  localparam logic [FUNC_W-1:0] F_WRITE   = 3'd0;
  localparam logic [FUNC_W-1:0] F_READ    = 3'd1;
  localparam logic [FUNC_W-1:0] F_CUR_ON  = 3'd2;
  localparam logic [FUNC_W-1:0] F_CUR_OFF = 3'd3;
  localparam logic [FUNC_W-1:0] F_MOVE    = 3'd4;
  localparam logic [FUNC_W-1:0] F_RESTART = 3'd5;
  localparam logic [FUNC_W-1:0] F_FIND    = 3'd6;

  localparam logic [1:0] DOP_SET     = 2'd0;
  localparam logic [1:0] DOP_CLR     = 2'd1;
  localparam logic [1:0] DOP_SET_CHG = 2'd2;

  typedef struct packed {
    logic       load;
    logic       tgt_cursor;
    logic       calc;
    logic       rd;
    logic       dirty_wr;
    logic [1:0] dop;
    logic       cell_wr;
    logic       cursor_upd;
    logic       scan_rst;
    logic       scan_start;
    logic       scan_rd;
    logic       scan_next;
    logic       scan_take;
    logic       div_step;
    logic       clear_step;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic              clear_done;
    logic [FUNC_W-1:0] func;
    logic              cursor_on;
    logic              scan_nz;
    logic              scan_last;
    logic              div_done;
    logic              out_busy;
  } stat_t;

  function automatic logic [DBIT_W-1:0] lowest_set(input logic [DWORD_W-1:0] w);
    logic [DWORD_W-1:0] v;
    logic [DBIT_W-1:0]  p;
    v = w;
    p = '0;
    if (v[15:0] == 16'd0) begin
      v = v >> 16;
      p[4] = 1'b1;
    end
    if (v[7:0] == 8'd0) begin
      v = v >> 8;
      p[3] = 1'b1;
    end
    if (v[3:0] == 4'd0) begin
      v = v >> 4;
      p[2] = 1'b1;
    end
    if (v[1:0] == 2'd0) begin
      v = v >> 2;
      p[1] = 1'b1;
    end
    if (v[0] == 1'b0) begin
      p[0] = 1'b1;
    end
    return p;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/dtcb_if.sv
// Request and response channel interfaces of the cell buffer.
// Depends on dtcb_pkg for field widths.
`default_nettype none

interface dtcb_req_if import dtcb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [DATA_W-1:0] wdata;

  modport source (output valid, func, col, row, wdata, input ready);
  modport sink   (input valid, func, col, row, wdata, output ready);
endinterface

interface dtcb_rsp_if import dtcb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] rdata;
  logic              found;
  logic [COL_W-1:0]  found_col;
  logic [ROW_W-1:0]  found_row;

  modport source (output valid, rdata, found, found_col, found_row, input ready);
  modport sink   (input valid, rdata, found, found_col, found_row, output ready);
endinterface

`default_nettype wire

FILE: rtl/dtcb_ctrl.sv
// Sequencing state machine of the cell buffer: issues datapath commands.
// Depends on dtcb_pkg for command, status and function codes.
`default_nettype none

module dtcb_ctrl import dtcb_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_RD       = 4'd3;
  localparam logic [3:0] S_MOD      = 4'd4;
  localparam logic [3:0] S_SCAN_RD  = 4'd5;
  localparam logic [3:0] S_SCAN_CHK = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;
  localparam logic [3:0] S_DONE     = 4'd8;

  logic [3:0] state, state_next;
  logic       second, second_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd         = '0;
    state_next  = state;
    second_next = second;
    case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        second_next = 1'b0;
        case (stat.func)
          F_WRITE, F_READ: begin
            cmd.calc   = 1'b1;
            state_next = S_RD;
          end
          F_CUR_ON, F_CUR_OFF: begin
            cmd.calc       = 1'b1;
            cmd.tgt_cursor = 1'b1;
            state_next     = S_RD;
          end
          F_MOVE: begin
            if (stat.cursor_on) begin
              cmd.calc       = 1'b1;
              cmd.tgt_cursor = 1'b1;
              state_next     = S_RD;
            end else begin
              cmd.cursor_upd = 1'b1;
              state_next     = S_DONE;
            end
          end
          F_RESTART: begin
            cmd.scan_rst = 1'b1;
            state_next   = S_DONE;
          end
          F_FIND: begin
            cmd.scan_start = 1'b1;
            state_next     = S_SCAN_RD;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_RD: begin
        cmd.rd     = 1'b1;
        state_next = S_MOD;
      end
      S_MOD: begin
        cmd.dirty_wr = 1'b1;
        case (stat.func)
          F_WRITE: begin
            cmd.cell_wr = 1'b1;
            cmd.dop     = DOP_SET_CHG;
            state_next  = S_DONE;
          end
          F_READ: begin
            cmd.dop    = DOP_CLR;
            state_next = S_DONE;
          end
          F_MOVE: begin
            cmd.dop = DOP_SET;
            if (!second) begin
              cmd.calc    = 1'b1;
              second_next = 1'b1;
              state_next  = S_RD;
            end else begin
              cmd.cursor_upd = 1'b1;
              state_next     = S_DONE;
            end
          end
          default: begin
            cmd.dop        = DOP_SET;
            cmd.cursor_upd = 1'b1;
            state_next     = S_DONE;
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (stat.scan_nz) begin
          cmd.scan_take = 1'b1;
          state_next    = S_DIV;
        end else if (stat.scan_last) begin
          state_next = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SCAN_RD;
        end
      end
      S_DIV: begin
        if (stat.div_done) state_next = S_DONE;
        else cmd.div_step = 1'b1;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_CLEAR;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      second <= second_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dtcb_datapath.sv
// Cell store, dirty-word store, cursor and scan registers, divider and result register.
// Depends on dtcb_pkg; driven by commands from dtcb_ctrl.
`default_nettype none

module dtcb_datapath import dtcb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             stat,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  input  logic [DATA_W-1:0] in_wdata,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] rdata,
  output logic              found,
  output logic [COL_W-1:0]  found_col,
  output logic [ROW_W-1:0]  found_row
);

  localparam int CELLS  = COLUMNS * ROWS;
  localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DWORDS = (CELLS + DWORD_W - 1) / DWORD_W;
  localparam int WA_W   = (DWORDS > 1) ? $clog2(DWORDS) : 1;
  localparam int IDXX_W = WA_W + DBIT_W;
  localparam int CALC_W = (IDX_W > 13) ? IDX_W : 13;
  localparam int CW     = $clog2(COLUMNS + 1);
  localparam int CNT_W  = 2;
  localparam int SH     = IDX_W + CW;
  localparam int RECIP  = ((1 << SH) + COLUMNS - 1) / COLUMNS;
  localparam int PROD_W = IDX_W + SH + 1;
  localparam int QC_W   = IDX_W + CW;

  logic [DATA_W-1:0]  cmem [CELLS];
  logic [DWORD_W-1:0] dmem [DWORDS];

  logic [FUNC_W-1:0]  func_q;
  logic [COL_W-1:0]   col_q;
  logic [ROW_W-1:0]   row_q;
  logic [DATA_W-1:0]  wdata_q;
  logic               cur_on;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [IDX_W-1:0]   scan_pos;
  logic [IDX_W-1:0]   tgt_idx;
  logic               tgt_ok;
  logic [DATA_W-1:0]  cell_rd;
  logic [DWORD_W-1:0] dirty_rd;
  logic [IDX_W-1:0]   clr_ptr;
  logic [WA_W-1:0]    scan_word;
  logic               first_word;
  logic               hit;
  logic [IDX_W-1:0]   dvd;
  logic [IDX_W-1:0]   quot;
  logic [CW-1:0]      rem;
  logic [CNT_W-1:0]   div_cnt;

  logic [COL_W-1:0]    sel_col;
  logic [ROW_W-1:0]    sel_row;
  logic                sel_ok;
  logic [CALC_W-1:0]   sel_full;
  logic [IDXX_W-1:0]   tgt_x, clr_x, scan_x, hit_x;
  logic [DBIT_W-1:0]   tgt_bit, hit_bit;
  logic [DWORD_W-1:0]  bit_mask, dirty_new, scan_mask, masked;
  logic                changed;
  logic                cell_we, dirty_we;
  logic [IDX_W-1:0]    cell_wa;
  logic [DATA_W-1:0]   cell_wd;
  logic [WA_W-1:0]     dirty_wa, dirty_ra;
  logic [DWORD_W-1:0]  dirty_wd;
  logic [IDX_W-1:0]    hit_idx;
  logic [PROD_W-1:0]   prod;
  logic [QC_W-1:0]     quot_cols;
  logic [QC_W-1:0]     rem_full;
  logic [CW+COL_W-1:0] rem_x;
  logic [IDX_W+ROW_W-1:0] quot_x;

  assign sel_col  = cmd.tgt_cursor ? cur_col : col_q;
  assign sel_row  = cmd.tgt_cursor ? cur_row : row_q;
  assign sel_ok   = ({4'b0, sel_col} < 9'(COLUMNS)) && ({5'b0, sel_row} < 9'(ROWS));
  assign sel_full = CALC_W'(sel_row) * CALC_W'(COLUMNS) + CALC_W'(sel_col);

  assign tgt_x   = IDXX_W'(tgt_idx);
  assign tgt_bit = tgt_x[DBIT_W-1:0];
  assign clr_x   = IDXX_W'(clr_ptr);
  assign scan_x  = IDXX_W'(scan_pos);

  assign changed  = (cell_rd != wdata_q);
  assign bit_mask = DWORD_W'(1) << tgt_bit;

  always_comb begin
    case (cmd.dop)
      DOP_SET:     dirty_new = dirty_rd | bit_mask;
      DOP_CLR:     dirty_new = dirty_rd & ~bit_mask;
      DOP_SET_CHG: dirty_new = changed ? (dirty_rd | bit_mask) : dirty_rd;
      default:     dirty_new = dirty_rd;
    endcase
  end

  assign cell_we  = cmd.clear_step || (cmd.cell_wr && tgt_ok && changed);
  assign cell_wa  = cmd.clear_step ? clr_ptr : tgt_idx;
  assign cell_wd  = cmd.clear_step ? '0 : wdata_q;
  assign dirty_we = cmd.clear_step || (cmd.dirty_wr && tgt_ok);
  assign dirty_wa = cmd.clear_step ? clr_x[IDXX_W-1:DBIT_W] : tgt_x[IDXX_W-1:DBIT_W];
  assign dirty_wd = cmd.clear_step ? '0 : dirty_new;
  assign dirty_ra = cmd.scan_rd ? scan_word : tgt_x[IDXX_W-1:DBIT_W];

  assign scan_mask = first_word ? ({DWORD_W{1'b1}} << scan_x[DBIT_W-1:0])
                                : {DWORD_W{1'b1}};
  assign masked    = dirty_rd & scan_mask;
  assign hit_bit   = lowest_set(masked);
  assign hit_x     = {scan_word, hit_bit};
  assign hit_idx   = hit_x[IDX_W-1:0];

  assign prod      = PROD_W'(dvd) * PROD_W'(RECIP);
  assign quot_cols = QC_W'(quot) * QC_W'(COLUMNS);
  assign rem_full  = QC_W'(dvd) - quot_cols;
  assign rem_x     = {{COL_W{1'b0}}, rem};
  assign quot_x    = {{ROW_W{1'b0}}, quot};

  assign stat.clear_done = (clr_ptr == IDX_W'(CELLS - 1));
  assign stat.func       = func_q;
  assign stat.cursor_on  = cur_on;
  assign stat.scan_nz    = (masked != '0);
  assign stat.scan_last  = (scan_word == WA_W'(DWORDS - 1));
  assign stat.div_done   = (div_cnt == '0);
  assign stat.out_busy   = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cell_we) cmem[cell_wa] <= cell_wd;
    if (cmd.rd) cell_rd <= cmem[tgt_idx];
    if (dirty_we) dmem[dirty_wa] <= dirty_wd;
    if (cmd.rd || cmd.scan_rd) dirty_rd <= dmem[dirty_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= in_func;
      col_q   <= in_col;
      row_q   <= in_row;
      wdata_q <= in_wdata;
    end
    if (cmd.calc) begin
      tgt_idx <= sel_full[IDX_W-1:0];
      tgt_ok  <= sel_ok;
    end
    if (cmd.scan_take) begin
      dvd  <= hit_idx;
      quot <= '0;
      rem  <= '0;
    end else if (cmd.div_step) begin
      quot <= prod[SH +: IDX_W];
      rem  <= rem_full[CW-1:0];
    end
    if (cmd.res_load) begin
      rdata     <= (func_q == F_READ && tgt_ok) ? cell_rd : '0;
      found     <= hit;
      found_col <= hit ? rem_x[COL_W-1:0] : '0;
      found_row <= hit ? quot_x[ROW_W-1:0] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_on     <= 1'b0;
      cur_col    <= '0;
      cur_row    <= '0;
      scan_pos   <= '0;
      clr_ptr    <= '0;
      scan_word  <= '0;
      first_word <= 1'b0;
      hit        <= 1'b0;
      div_cnt    <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.clear_step) clr_ptr <= clr_ptr + IDX_W'(1);
      if (cmd.cursor_upd) begin
        case (func_q)
          F_CUR_ON:  cur_on <= 1'b1;
          F_CUR_OFF: cur_on <= 1'b0;
          F_MOVE: begin
            cur_col <= col_q;
            cur_row <= row_q;
          end
          default: cur_on <= cur_on;
        endcase
      end
      if (cmd.scan_rst) scan_pos <= '0;
      else if (cmd.scan_take) scan_pos <= hit_idx;
      if (cmd.scan_start) begin
        scan_word  <= scan_x[IDXX_W-1:DBIT_W];
        first_word <= 1'b1;
      end else if (cmd.scan_next) begin
        scan_word  <= scan_word + WA_W'(1);
        first_word <= 1'b0;
      end
      if (cmd.load) hit <= 1'b0;
      else if (cmd.scan_take) hit <= 1'b1;
      if (cmd.scan_take) div_cnt <= CNT_W'(2);
      else if (cmd.div_step) div_cnt <= div_cnt - CNT_W'(1);
      if (cmd.res_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/dirty_tracked_cell_buffer_core.sv
// Top level of the dirty-tracked display cell buffer: controller plus datapath.
// Depends on dtcb_pkg, dtcb_if, dtcb_ctrl, dtcb_datapath and the assertion macros.
//
//   channel | modport | transaction
//   req     | sink    | func, col, row, wdata
//   rsp     | source  | rdata, found, found_col, found_row
//
// Write, read and cursor on/off read the target cell and dirty word, then write back; move
// with cursor on does so for the old and then the new cursor cell. Restart scan, move with
// cursor off and unused codes go straight from decode to the result. Find next scans 32-cell
// dirty words and splits a found index into row and column by reciprocal multiplication.
// After reset a clearing pass over all COLUMNS*ROWS cells (512 by default) holds req.ready low.
// The result waits in an output register; the next transaction is accepted meanwhile.
`default_nettype none

`include "dirty_tracked_cell_buffer_core_assert.svh"

module dirty_tracked_cell_buffer_core import dtcb_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input logic        clk,
  input logic        rst,
  dtcb_req_if.sink   req,
  dtcb_rsp_if.source rsp
);

  cmd_t  cmd;
  stat_t stat;
  logic  in_ready;

  assign req.ready = in_ready;

  dtcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dtcb_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_func   (req.func),
    .in_col    (req.col),
    .in_row    (req.row),
    .in_wdata  (req.wdata),
    .out_ready (rsp.ready),
    .out_valid (rsp.valid),
    .rdata     (rsp.rdata),
    .found     (rsp.found),
    .found_col (rsp.found_col),
    .found_row (rsp.found_row)
  );

  `DTCB_ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  `DTCB_ASSERT_IMP(a_read_not_found, clk, rst, rsp.valid && rsp.rdata != '0, !rsp.found)
  `DTCB_ASSERT_IMP(a_miss_no_coords, clk, rst, rsp.valid && !rsp.found, rsp.found_col == '0 && rsp.found_row == '0)

endmodule

`default_nettype wire

FILE: tb/dirty_tracked_cell_buffer_core_tb.sv
`timescale 1ns / 100ps
// Testbench for dirty_tracked_cell_buffer_core: directed and random cell, cursor and scan
// transactions, checked against a scoreboard that tracks cells, dirty bits and the scan position.
// Depends on dtcb_pkg, dtcb_if and the cell buffer RTL.

module dirty_tracked_cell_buffer_core_tb import dtcb_pkg::*; ();

  localparam int CELLS = COLUMNS_DEF * ROWS_DEF;
  localparam logic [FUNC_W-1:0] F_UNUSED = 3'd7;
  localparam int TOTAL_ITEMS = 1400;
  localparam int TAIL_ITEMS = 150;
  localparam int HOLD_AT = 500;
  localparam int DRAIN_AT = 900;
  localparam int LONG_HOLD = 300;
  localparam int IDLE_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 60;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [DATA_W-1:0] rdata;
    logic              found;
    logic [COL_W-1:0]  found_col;
    logic [ROW_W-1:0]  found_row;
  } reply_t;

  class cell_buffer_scoreboard;
    logic [DATA_W-1:0] cells [CELLS];
    bit                dirty [CELLS];
    bit                cursor_shown;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    int                scan_pos;
    reply_t            pending_replies [$];
    reply_t            last_reply;
    int                errors;

    function new();
      foreach (cells[i]) begin
        cells[i] = '0;
        dirty[i] = 1'b0;
      end
      cursor_shown = 1'b0;
      cursor_col = '0;
      cursor_row = '0;
      scan_pos = 0;
      last_reply = '0;
      errors = 0;
    endfunction

    function int index_of(logic [COL_W-1:0] c, logic [ROW_W-1:0] r);
      return int'(r) * COLUMNS_DEF + int'(c);
    endfunction

    function void note_command(logic [FUNC_W-1:0] f, logic [COL_W-1:0] c,
                               logic [ROW_W-1:0] r, logic [DATA_W-1:0] w);
      reply_t rep;
      int     idx;
      int     i;
      rep = '0;
      idx = index_of(c, r);
      case (f)
        F_WRITE: begin
          if (cells[idx] != w) begin
            cells[idx] = w;
            dirty[idx] = 1'b1;
          end
        end
        F_READ: begin
          dirty[idx] = 1'b0;
          rep.rdata = cells[idx];
        end
        F_CUR_ON, F_CUR_OFF: begin
          dirty[index_of(cursor_col, cursor_row)] = 1'b1;
          cursor_shown = (f == F_CUR_ON);
        end
        F_MOVE: begin
          if (cursor_shown) begin
            dirty[index_of(cursor_col, cursor_row)] = 1'b1;
            dirty[idx] = 1'b1;
          end
          cursor_col = c;
          cursor_row = r;
        end
        F_RESTART: scan_pos = 0;
        F_FIND: begin
          for (i = scan_pos; i < CELLS && !rep.found; i++) begin
            if (dirty[i]) begin
              scan_pos = i;
              rep.found = 1'b1;
              rep.found_col = COL_W'(i % COLUMNS_DEF);
              rep.found_row = ROW_W'(i / COLUMNS_DEF);
            end
          end
        end
        default: ;
      endcase
      last_reply = rep;
      pending_replies.push_back(rep);
    endfunction

    function void check_response(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected response: rdata=%0h found=%0b col=%0d row=%0d",
                   got.rdata, got.found, got.found_col, got.found_row);
        return;
      end
      want = pending_replies.pop_front();
      if (got.rdata !== want.rdata || got.found !== want.found ||
          got.found_col !== want.found_col || got.found_row !== want.found_row) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("response error: expected %0h/%0b/%0d/%0d, got %0h/%0b/%0d/%0d",
                   want.rdata, want.found, want.found_col, want.found_row,
                   got.rdata, got.found, got.found_col, got.found_row);
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  dtcb_req_if req_if ();
  dtcb_rsp_if rsp_if ();

  dirty_tracked_cell_buffer_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  cell_buffer_scoreboard sb;

  int items_sent = 0;
  int send_gap_pct = 0;
  int reply_stall_pct = 0;
  bit quiet_tail = 1'b0;
  bit hold_replies = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  function automatic void pick_cell(output logic [COL_W-1:0] c, output logic [ROW_W-1:0] r);
    int mode;
    mode = $urandom_range(9);
    if (mode < 5) begin
      c = COL_W'($urandom_range(COLUMNS_DEF - 1));
      r = ROW_W'($urandom_range(ROWS_DEF - 1));
    end else if (mode < 8) begin
      c = COL_W'($urandom_range(3));
      r = ROW_W'($urandom_range(1));
    end else begin
      c = $urandom_range(1) ? COL_W'(COLUMNS_DEF - 1) : '0;
      r = $urandom_range(1) ? ROW_W'(ROWS_DEF - 1) : '0;
    end
  endfunction

  // Call right after a falling edge; returns right after the falling edge past acceptance.
  task automatic send_command(input logic [FUNC_W-1:0] f, input logic [COL_W-1:0] c,
                              input logic [ROW_W-1:0] r, input logic [DATA_W-1:0] w);
    int gap;
    gap = 0;
    if (!quiet_tail && $urandom_range(99) < send_gap_pct) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid = 1'b1;
    req_if.func = f;
    req_if.col = c;
    req_if.row = r;
    req_if.wdata = w;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_command(f, c, r, w);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (sb.pending_replies.size() != 0) @(negedge clk);
  endtask

  task automatic send_random_op();
    logic [FUNC_W-1:0] f;
    logic [COL_W-1:0]  c;
    logic [ROW_W-1:0]  r;
    logic [DATA_W-1:0] w;
    int                pick;
    pick_cell(c, r);
    w = DATA_W'($urandom_range(255));
    pick = $urandom_range(99);
    if (pick < 35) begin
      f = F_WRITE;
      if ($urandom_range(3) == 0) w = sb.cells[sb.index_of(c, r)];
    end else if (pick < 55) f = F_READ;
    else if (pick < 75) f = F_FIND;
    else if (pick < 81) f = F_RESTART;
    else if (pick < 86) f = F_CUR_ON;
    else if (pick < 90) f = F_CUR_OFF;
    else if (pick < 97) f = F_MOVE;
    else f = F_UNUSED;
    send_command(f, c, r, w);
  endtask

  // Walk the dirty cells from the top, reading back each one found.
  task automatic refresh_sweep();
    int steps;
    steps = $urandom_range(1, 12);
    send_command(F_RESTART, COL_W'($urandom), ROW_W'($urandom), DATA_W'($urandom));
    repeat (steps) begin
      send_command(F_FIND, COL_W'($urandom), ROW_W'($urandom), DATA_W'($urandom));
      if (sb.last_reply.found)
        send_command(F_READ, sb.last_reply.found_col, sb.last_reply.found_row,
                     DATA_W'($urandom));
    end
  endtask

  initial begin
    int next_retune;
    bit held_once;
    bit drained_once;
    next_retune = 0;
    held_once = 1'b0;
    drained_once = 1'b0;
    sb = new();
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.func = F_WRITE;
    req_if.col = '0;
    req_if.row = '0;
    req_if.wdata = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_command(F_FIND, 5'd0, 4'd0, 8'd0);
    send_command(F_WRITE, 5'd5, 4'd2, 8'd0);
    send_command(F_FIND, 5'd31, 4'd15, 8'hFF);
    send_command(F_WRITE, 5'd31, 4'd15, 8'hFF);
    send_command(F_WRITE, 5'd0, 4'd0, 8'h55);
    send_command(F_WRITE, 5'd1, 4'd0, 8'hAA);
    send_command(F_FIND, 5'd0, 4'd0, 8'd0);
    send_command(F_READ, 5'd0, 4'd0, 8'd0);
    send_command(F_FIND, 5'd0, 4'd0, 8'd0);
    send_command(F_FIND, 5'd0, 4'd0, 8'd0);
    send_command(F_READ, 5'd1, 4'd0, 8'd0);
    send_command(F_FIND, 5'd0, 4'd0, 8'd0);
    send_command(F_READ, 5'd31, 4'd15, 8'd0);
    send_command(F_FIND, 5'd0, 4'd0, 8'd0);
    send_command(F_RESTART, 5'd31, 4'd15, 8'hFF);
    send_command(F_CUR_ON, 5'd0, 4'd0, 8'd0);
    send_command(F_MOVE, 5'd31, 4'd15, 8'd0);
    send_command(F_CUR_OFF, 5'd0, 4'd0, 8'd0);
    send_command(F_MOVE, 5'd10, 4'd3, 8'd0);
    send_command(F_CUR_ON, 5'd0, 4'd0, 8'd0);
    send_command(F_UNUSED, 5'd31, 4'd15, 8'hFF);
    send_command(F_FIND, 5'd0, 4'd0, 8'd0);
    send_command(F_READ, 5'd0, 4'd0, 8'd0);
    send_command(F_WRITE, 5'd31, 4'd15, 8'hFF);
    send_command(F_READ, 5'd17, 4'd9, 8'd0);

    while (items_sent < TOTAL_ITEMS) begin
      if (items_sent >= next_retune) begin
        next_retune += 100;
        send_gap_pct = pick_idle_pct();
        reply_stall_pct = pick_idle_pct();
      end
      if (!held_once && items_sent >= HOLD_AT) begin
        held_once = 1'b1;
        send_gap_pct = 0;
        hold_replies = 1'b1;
        repeat (24) send_random_op();
      end
      if (!drained_once && items_sent >= DRAIN_AT) begin
        drained_once = 1'b1;
        wait_drained();
      end
      if (items_sent >= TOTAL_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
      if ($urandom_range(99) < 12) refresh_sweep();
      else send_random_op();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_replies) begin
        hold_replies = 1'b0;
        rsp_if.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end
      if (stall_left == 0 && !quiet_tail && $urandom_range(99) < reply_stall_pct)
        stall_left = $urandom_range(1, 17);
      if (stall_left > 0) begin
        rsp_if.ready = 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
      sb.check_response({rsp_if.rdata, rsp_if.found, rsp_if.found_col, rsp_if.found_row});
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
